[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the node pool rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, masked while reset is high
`define ASSERT_RST(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// checked property, also during reset
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[sv/llnp_pkg.sv]
// ---------------------------------------------------------------------------
// llnp_pkg
// codes, sequencer states and memory write strobes of the node pool
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package llnp_pkg;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_NOTFOUND  = 2'd2;
  localparam logic [1:0] ST_LASTNODE  = 2'd3;

  localparam int VAL_W = 32;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_APP_LINK,
    S_APP_TAIL,
    S_SRCH,
    S_DEL_SUCC,
    S_DEL_COPY,
    S_DEL_FREE,
    S_RD
  } state_t;

  typedef struct packed {
    logic val_we;
    logic link_we;
  } mem_wr_t;

endpackage

[sv/llnp_store.sv]
// ---------------------------------------------------------------------------
// llnp_store
// value and link memories, one write port each, shared registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module llnp_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int LW    = 7
) (
  input  logic                        clk,
  input  llnp_pkg::mem_wr_t           wr,
  input  logic [AW-1:0]               val_waddr,
  input  logic [llnp_pkg::VAL_W-1:0]  val_wdata,
  input  logic [AW-1:0]               link_waddr,
  input  logic [LW-1:0]               link_wdata,
  input  logic [AW-1:0]               raddr,
  output logic [llnp_pkg::VAL_W-1:0]  val_rdata,
  output logic [LW-1:0]               link_rdata
);

  logic [llnp_pkg::VAL_W-1:0] val_mem [DEPTH];
  logic [LW-1:0]              link_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    val_rdata <= val_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[raddr];
  end

endmodule

[sv/linked_list_node_pool.sv]
// ---------------------------------------------------------------------------
// linked_list_node_pool
// singly linked list in a fixed node pool with a free list of spare nodes
// ---------------------------------------------------------------------------
// A request word (action, operand_value, target_node) is taken at a rising
// edge with start high and busy low. Exactly one result word comes back on
// status, found_index, node_value, next_of_node and head_index, valid for the
// single cycle in which done is high; the receiver cannot stall it.
// A request refused at once (pool exhausted, empty list, index out of pool)
// is answered straight from idle. Read passes through S_RD, append through
// S_APP_LINK and, when a tail link is patched, S_APP_TAIL, and delete through
// S_DEL_SUCC and, unless refused as the last node, S_DEL_COPY and S_DEL_FREE.
// A search stays in S_SRCH for each node it visits, up to POOL_SIZE nodes,
// reading one node per cycle from the single memory read port. busy stays
// high until done rises; a new request may be given in the cycle done is high.
// After reset the link memory is swept to its initial free chain, one entry a
// cycle, over all POOL_SIZE entries with busy high; the list is then empty and
// all nodes are free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linked_list_node_pool #(
  parameter int POOL_SIZE = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          action,
  input  logic signed [llnp_pkg::VAL_W-1:0]   operand_value,
  input  logic [$clog2(POOL_SIZE)-1:0]        target_node,
  output logic                                done,
  output logic [1:0]                          status,
  output logic [$clog2(POOL_SIZE+1)-1:0]      found_index,
  output logic signed [llnp_pkg::VAL_W-1:0]   node_value,
  output logic [$clog2(POOL_SIZE+1)-1:0]      next_of_node,
  output logic [$clog2(POOL_SIZE+1)-1:0]      head_index
);

  localparam int IW = $clog2(POOL_SIZE);
  localparam int LW = $clog2(POOL_SIZE + 1);
  localparam logic [LW-1:0] NIL  = LW'(POOL_SIZE);
  localparam logic [IW-1:0] LAST = IW'(POOL_SIZE - 1);

  llnp_pkg::state_t state, state_next;

  logic [IW-1:0]              clr_cnt, clr_cnt_next;
  logic [LW-1:0]              free_head, free_head_next;
  logic [LW-1:0]              list_head, list_head_next;
  logic [LW-1:0]              list_tail, list_tail_next;
  logic [LW-1:0]              cur, cur_next;
  logic [IW-1:0]              steps, steps_next;
  logic [IW-1:0]              idx_r, idx_r_next;
  logic [llnp_pkg::VAL_W-1:0] key, key_next;
  logic                       done_next;
  logic [1:0]                 status_next;
  logic [LW-1:0]              found_next, nnext_next;
  logic [llnp_pkg::VAL_W-1:0] nval_next;

  llnp_pkg::mem_wr_t          wr;
  logic [IW-1:0]              val_waddr, link_waddr, raddr;
  logic [llnp_pkg::VAL_W-1:0] val_wdata, val_rdata;
  logic [LW-1:0]              link_wdata, link_rdata, rlink;

  llnp_store #(
    .DEPTH (POOL_SIZE),
    .AW    (IW),
    .LW    (LW)
  ) u_store (
    .clk        (clk),
    .wr         (wr),
    .val_waddr  (val_waddr),
    .val_wdata  (val_wdata),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .raddr      (raddr),
    .val_rdata  (val_rdata),
    .link_rdata (link_rdata)
  );

  // stray links read as end of list
  assign rlink = (link_rdata >= NIL) ? NIL : link_rdata;

  assign busy       = (state != llnp_pkg::S_IDLE);
  assign head_index = list_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= llnp_pkg::S_CLEAR;
      clr_cnt   <= '0;
      free_head <= '0;
      list_head <= NIL;
      list_tail <= NIL;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      free_head <= free_head_next;
      list_head <= list_head_next;
      list_tail <= list_tail_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur          <= cur_next;
    steps        <= steps_next;
    idx_r        <= idx_r_next;
    key          <= key_next;
    status       <= status_next;
    found_index  <= found_next;
    node_value   <= nval_next;
    next_of_node <= nnext_next;
  end

  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    free_head_next = free_head;
    list_head_next = list_head;
    list_tail_next = list_tail;
    cur_next       = cur;
    steps_next     = steps;
    idx_r_next     = idx_r;
    key_next       = key;
    done_next      = 1'b0;
    status_next    = status;
    found_next     = found_index;
    nval_next      = node_value;
    nnext_next     = next_of_node;
    wr             = '0;
    val_waddr      = '0;
    val_wdata      = key;
    link_waddr     = '0;
    link_wdata     = NIL;
    raddr          = '0;

    case (state)
      llnp_pkg::S_CLEAR: begin
        wr.link_we   = 1'b1;
        link_waddr   = clr_cnt;
        link_wdata   = LW'(clr_cnt) + LW'(1);
        clr_cnt_next = clr_cnt + IW'(1);
        if (clr_cnt == LAST) begin
          state_next = llnp_pkg::S_IDLE;
        end
      end

      llnp_pkg::S_IDLE: begin
        if (start) begin
          key_next    = operand_value;
          idx_r_next  = target_node;
          status_next = llnp_pkg::ST_OK;
          found_next  = NIL;
          nval_next   = '0;
          nnext_next  = NIL;
          case (action)
            llnp_pkg::ACT_APPEND: begin
              if (free_head == NIL) begin
                status_next = llnp_pkg::ST_EXHAUSTED;
                done_next   = 1'b1;
              end else begin
                raddr      = free_head[IW-1:0];
                state_next = llnp_pkg::S_APP_LINK;
              end
            end
            llnp_pkg::ACT_SEARCH: begin
              if (list_head == NIL) begin
                status_next = llnp_pkg::ST_NOTFOUND;
                done_next   = 1'b1;
              end else begin
                raddr      = list_head[IW-1:0];
                cur_next   = list_head;
                steps_next = '0;
                state_next = llnp_pkg::S_SRCH;
              end
            end
            llnp_pkg::ACT_DELETE: begin
              if (LW'(target_node) >= NIL) begin
                status_next = llnp_pkg::ST_LASTNODE;
                done_next   = 1'b1;
              end else begin
                raddr      = target_node;
                state_next = llnp_pkg::S_DEL_SUCC;
              end
            end
            default: begin
              if (LW'(target_node) >= NIL) begin
                status_next = llnp_pkg::ST_NOTFOUND;
                done_next   = 1'b1;
              end else begin
                raddr      = target_node;
                state_next = llnp_pkg::S_RD;
              end
            end
          endcase
        end
      end

      llnp_pkg::S_APP_LINK: begin
        free_head_next = rlink;
        wr.val_we      = 1'b1;
        val_waddr      = free_head[IW-1:0];
        val_wdata      = key;
        wr.link_we     = 1'b1;
        link_waddr     = free_head[IW-1:0];
        link_wdata     = NIL;
        found_next     = free_head;
        if (list_head != NIL && list_tail != NIL) begin
          cur_next   = free_head;
          state_next = llnp_pkg::S_APP_TAIL;
        end else begin
          if (list_head == NIL) begin
            list_head_next = free_head;
          end
          list_tail_next = free_head;
          done_next      = 1'b1;
          state_next     = llnp_pkg::S_IDLE;
        end
      end

      llnp_pkg::S_APP_TAIL: begin
        wr.link_we     = 1'b1;
        link_waddr     = list_tail[IW-1:0];
        link_wdata     = cur;
        list_tail_next = cur;
        done_next      = 1'b1;
        state_next     = llnp_pkg::S_IDLE;
      end

      llnp_pkg::S_SRCH: begin
        if (val_rdata == key) begin
          found_next = cur;
          done_next  = 1'b1;
          state_next = llnp_pkg::S_IDLE;
        end else if (rlink == NIL || steps == LAST) begin
          status_next = llnp_pkg::ST_NOTFOUND;
          done_next   = 1'b1;
          state_next  = llnp_pkg::S_IDLE;
        end else begin
          raddr      = rlink[IW-1:0];
          cur_next   = rlink;
          steps_next = steps + IW'(1);
        end
      end

      llnp_pkg::S_DEL_SUCC: begin
        if (rlink == NIL) begin
          status_next = llnp_pkg::ST_LASTNODE;
          done_next   = 1'b1;
          state_next  = llnp_pkg::S_IDLE;
        end else begin
          raddr      = rlink[IW-1:0];
          cur_next   = rlink;
          state_next = llnp_pkg::S_DEL_COPY;
        end
      end

      llnp_pkg::S_DEL_COPY: begin
        wr.val_we  = 1'b1;
        val_waddr  = idx_r;
        val_wdata  = val_rdata;
        wr.link_we = 1'b1;
        link_waddr = idx_r;
        link_wdata = rlink;
        state_next = llnp_pkg::S_DEL_FREE;
      end

      llnp_pkg::S_DEL_FREE: begin
        wr.link_we     = 1'b1;
        link_waddr     = cur[IW-1:0];
        link_wdata     = free_head;
        free_head_next = cur;
        if (list_tail == cur) begin
          list_tail_next = LW'(idx_r);
        end
        found_next = LW'(idx_r);
        done_next  = 1'b1;
        state_next = llnp_pkg::S_IDLE;
      end

      llnp_pkg::S_RD: begin
        found_next = LW'(idx_r);
        nval_next  = val_rdata;
        nnext_next = rlink;
        done_next  = 1'b1;
        state_next = llnp_pkg::S_IDLE;
      end

      default: begin
        state_next = llnp_pkg::S_IDLE;
      end
    endcase
  end

  `ASSERT_RST(a_accept_progress, clk, rst, ((start && !busy) |=> (done || busy)), "accepted word neither finished nor in progress")
  `ASSERT_RST(a_fail_no_node, clk, rst, ((done && status != llnp_pkg::ST_OK) |-> (found_index == NIL)), "failed request reports a node")
  `ASSERT_RST(a_walk_bound, clk, rst, ((state == llnp_pkg::S_SRCH) |-> (LW'(steps) < NIL)), "search walk past pool size")
  `ASSERT_ALWAYS(a_reset_clear, clk, (rst |=> (state == llnp_pkg::S_CLEAR && !done)), "reset did not start link sweep")

endmodule

[test/tb_linked_list_node_pool.sv]
// ---------------------------------------------------------------------------
// tb_linked_list_node_pool
// self-checking bench for the linked list node pool
// ---------------------------------------------------------------------------
// A shadow copy of the pool (values, links, head, tail and free list) is
// updated for every request word accepted on start/busy. The expected answer
// is queued and then compared field by field with each word strobed by done.
// The directed part covers the empty list, extreme values, duplicate keys,
// the refused last-node delete, a delete that frees the tail, a delete at a
// node outside the list and a read of a freed node. It then fills the pool
// to exhaustion and drains it again. The random part alternates growing and
// shrinking phases. Random idle gaps are inserted between request words. No
// request is sent that would read a value entry that was never written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_linked_list_node_pool;

  localparam int         POOL = 64;
  localparam logic [6:0] NIL  = 7'd64;

  typedef struct {
    logic [1:0]         status;
    logic [6:0]         found;
    logic signed [31:0] value;
    logic [6:0]         nxt;
    logic [6:0]         head;
  } pool_answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         action = llnp_pkg::ACT_APPEND;
  logic signed [31:0] operand_value = '0;
  logic [5:0]         target_node = '0;
  logic               done;
  logic [1:0]         status;
  logic [6:0]         found_index;
  logic signed [31:0] node_value;
  logic [6:0]         next_of_node;
  logic [6:0]         head_index;

  logic signed [31:0] shadow_val [POOL];
  logic [6:0]         shadow_link [POOL];
  bit                 shadow_written [POOL];
  logic [6:0]         shadow_head;
  logic [6:0]         shadow_tail;
  logic [6:0]         shadow_free;

  pool_answer_t       pending_answers [$];
  pool_answer_t       due_answer;
  int                 mismatch_count = 0;
  bit                 quiet = 1'b0;

  linked_list_node_pool #(
    .POOL_SIZE(POOL)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .operand_value(operand_value),
    .target_node(target_node),
    .done(done),
    .status(status),
    .found_index(found_index),
    .node_value(node_value),
    .next_of_node(next_of_node),
    .head_index(head_index)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void shadow_reset();
    for (int i = 0; i < POOL; i++) begin
      shadow_val[i] = '0;
      shadow_written[i] = 1'b0;
      shadow_link[i] = 7'(i + 1);
    end
    shadow_head = NIL;
    shadow_tail = NIL;
    shadow_free = '0;
  endfunction

  // stray links count as end of list
  function automatic logic [6:0] link_after(logic [6:0] node);
    logic [6:0] l;
    if (node >= NIL) return NIL;
    l = shadow_link[node[5:0]];
    return (l >= NIL) ? NIL : l;
  endfunction

  function automatic pool_answer_t pool_apply(logic [1:0] act, logic signed [31:0] v,
                                              logic [5:0] idx);
    pool_answer_t r;
    logic [6:0]   n;
    logic [6:0]   succ;
    logic [6:0]   cur;
    int           steps;
    r.status = llnp_pkg::ST_OK;
    r.found = NIL;
    r.value = '0;
    r.nxt = NIL;
    case (act)
      llnp_pkg::ACT_APPEND: begin
        n = (shadow_free >= NIL) ? NIL : shadow_free;
        if (n == NIL) begin
          r.status = llnp_pkg::ST_EXHAUSTED;
        end else begin
          shadow_free = link_after(n);
          shadow_val[n[5:0]] = v;
          shadow_written[n[5:0]] = 1'b1;
          shadow_link[n[5:0]] = NIL;
          if (shadow_head >= NIL) shadow_head = n;
          else if (shadow_tail < NIL) shadow_link[shadow_tail[5:0]] = n;
          shadow_tail = n;
          r.found = n;
        end
      end
      llnp_pkg::ACT_SEARCH: begin
        cur = (shadow_head >= NIL) ? NIL : shadow_head;
        steps = 0;
        r.status = llnp_pkg::ST_NOTFOUND;
        while (cur != NIL && steps < POOL && r.status != llnp_pkg::ST_OK) begin
          if (shadow_val[cur[5:0]] == v) begin
            r.status = llnp_pkg::ST_OK;
            r.found = cur;
          end else begin
            cur = link_after(cur);
            steps++;
          end
        end
      end
      llnp_pkg::ACT_DELETE: begin
        succ = link_after({1'b0, idx});
        if (succ == NIL) begin
          r.status = llnp_pkg::ST_LASTNODE;
        end else begin
          shadow_val[idx] = shadow_val[succ[5:0]];
          shadow_written[idx] = shadow_written[succ[5:0]];
          shadow_link[idx] = link_after(succ);
          shadow_link[succ[5:0]] = (shadow_free >= NIL) ? NIL : shadow_free;
          shadow_free = succ;
          if (shadow_tail == succ) shadow_tail = {1'b0, idx};
          r.found = {1'b0, idx};
        end
      end
      default: begin
        // a 6-bit index is always inside the pool
        r.found = {1'b0, idx};
        r.value = shadow_val[idx];
        r.nxt = link_after({1'b0, idx});
      end
    endcase
    r.head = (shadow_head >= NIL) ? NIL : shadow_head;
    return r;
  endfunction

  // false when the request would touch a value entry never written
  function automatic bit request_is_defined(logic [1:0] act, logic signed [31:0] v,
                                            logic [5:0] idx);
    logic [6:0] cur;
    logic [6:0] succ;
    int         steps;
    case (act)
      llnp_pkg::ACT_SEARCH: begin
        cur = (shadow_head >= NIL) ? NIL : shadow_head;
        for (steps = 0; steps < POOL && cur != NIL; steps++) begin
          if (!shadow_written[cur[5:0]]) return 1'b0;
          if (shadow_val[cur[5:0]] == v) return 1'b1;
          cur = link_after(cur);
        end
        return 1'b1;
      end
      llnp_pkg::ACT_DELETE: begin
        succ = link_after({1'b0, idx});
        return (succ == NIL) || shadow_written[succ[5:0]];
      end
      llnp_pkg::ACT_READ: return shadow_written[idx];
      default: return 1'b1;
    endcase
  endfunction

  function automatic int list_length();
    logic [6:0] cur;
    int         len;
    cur = shadow_head;
    len = 0;
    while (cur < NIL && len < POOL) begin
      cur = link_after(cur);
      len++;
    end
    return len;
  endfunction

  function automatic logic [5:0] pick_list_node();
    logic [6:0] cur;
    int         len;
    int         pos;
    len = list_length();
    if (len == 0) return 6'($urandom_range(0, POOL - 1));
    pos = $urandom_range(0, len - 1);
    cur = shadow_head;
    repeat (pos) cur = link_after(cur);
    return cur[5:0];
  endfunction

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 1)) return $urandom;
    case ($urandom_range(0, 5))
      0:       return 32'sd0;
      1:       return -32'sd1;
      2:       return 32'sh8000_0000;
      3:       return 32'sh7fff_ffff;
      default: return 32'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic int idle_cycles();
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_request(logic [1:0] act, logic signed [31:0] v, logic [5:0] idx);
    logic [1:0] a;
    int         gap;
    a = act;
    gap = idle_cycles();
    if (!request_is_defined(a, v, idx)) a = llnp_pkg::ACT_APPEND;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action <= a;
    operand_value <= v;
    target_node <= idx;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_answers.push_back(pool_apply(a, v, idx));
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("result word with no request outstanding");
        mismatch_count++;
      end else begin
        due_answer = pending_answers.pop_front();
        compare_field("status", 32'(due_answer.status), 32'(status));
        compare_field("found_index", 32'(due_answer.found), 32'(found_index));
        compare_field("node_value", due_answer.value, node_value);
        compare_field("next_of_node", 32'(due_answer.nxt), 32'(next_of_node));
        compare_field("head_index", 32'(due_answer.head), 32'(head_index));
      end
    end
  end

  task automatic test_empty_list();
    send_request(llnp_pkg::ACT_SEARCH, 32'sd0, 6'd0);
    send_request(llnp_pkg::ACT_DELETE, 32'sd0, 6'd63);
  endtask

  task automatic test_directed_edits();
    send_request(llnp_pkg::ACT_APPEND, 32'sh8000_0000, 6'd0);
    send_request(llnp_pkg::ACT_APPEND, 32'sh7fff_ffff, 6'd0);
    send_request(llnp_pkg::ACT_APPEND, 32'sd0, 6'd0);
    send_request(llnp_pkg::ACT_APPEND, -32'sd1, 6'd0);
    send_request(llnp_pkg::ACT_APPEND, 32'sh5555_5555, 6'd0);
    send_request(llnp_pkg::ACT_APPEND, 32'shaaaa_aaaa, 6'd0);
    send_request(llnp_pkg::ACT_APPEND, -32'sd1, 6'd0);
    send_request(llnp_pkg::ACT_SEARCH, 32'sh8000_0000, 6'd0);
    send_request(llnp_pkg::ACT_SEARCH, -32'sd1, 6'd0);
    send_request(llnp_pkg::ACT_SEARCH, 32'shaaaa_aaaa, 6'd0);
    send_request(llnp_pkg::ACT_SEARCH, 32'sd12345, 6'd0);
    send_request(llnp_pkg::ACT_READ, 32'sd0, 6'd0);
    send_request(llnp_pkg::ACT_READ, 32'sd0, 6'd6);
    // tail refused, then its predecessor takes over as tail
    send_request(llnp_pkg::ACT_DELETE, 32'sd0, 6'd6);
    send_request(llnp_pkg::ACT_DELETE, 32'sd0, 6'd5);
    send_request(llnp_pkg::ACT_APPEND, 32'sh1234_5678, 6'd0);
    send_request(llnp_pkg::ACT_DELETE, 32'sd0, 6'd2);
    send_request(llnp_pkg::ACT_READ, 32'sd0, 6'd3);
    send_request(llnp_pkg::ACT_DELETE, 32'sd0, 6'd0);
    // node 1 now sits on the free list
    send_request(llnp_pkg::ACT_DELETE, 32'sd0, 6'd1);
    send_request(llnp_pkg::ACT_READ, 32'sd0, 6'd1);
    send_request(llnp_pkg::ACT_APPEND, 32'sd42, 6'd0);
    send_request(llnp_pkg::ACT_SEARCH, 32'sd42, 6'd0);
  endtask

  task automatic test_pool_exhaustion();
    while (shadow_free < NIL) send_request(llnp_pkg::ACT_APPEND, $urandom, 6'($urandom));
    send_request(llnp_pkg::ACT_APPEND, $urandom, 6'd0);
    send_request(llnp_pkg::ACT_SEARCH, shadow_val[shadow_tail[5:0]], 6'd0);
    send_request(llnp_pkg::ACT_SEARCH, $urandom, 6'd0);
    send_request(llnp_pkg::ACT_READ, 32'sd0, pick_list_node());
    repeat (90) begin
      if (list_length() > 2) send_request(llnp_pkg::ACT_DELETE, $urandom, pick_list_node());
    end
  endtask

  task automatic random_request(bit grow);
    logic [5:0]         idx;
    logic signed [31:0] v;
    int                 p;
    p = $urandom_range(0, 99);
    idx = ($urandom_range(0, 3) != 0) ? pick_list_node() : 6'($urandom_range(0, POOL - 1));
    v = pick_value();
    if (p < (grow ? 45 : 12)) begin
      send_request(llnp_pkg::ACT_APPEND, v, idx);
    end else if (p < (grow ? 70 : 40)) begin
      if ($urandom_range(0, 1) && list_length() > 0) v = shadow_val[pick_list_node()];
      send_request(llnp_pkg::ACT_SEARCH, v, idx);
    end else if (p < (grow ? 85 : 80)) begin
      send_request(llnp_pkg::ACT_DELETE, v, idx);
    end else begin
      send_request(llnp_pkg::ACT_READ, v, idx);
    end
  endtask

  task automatic test_random_traffic();
    for (int blk = 0; blk < 12; blk++) begin
      quiet = (blk % 4 == 3);
      repeat (150) random_request(blk % 2 == 0);
    end
    quiet = 1'b0;
  endtask

  initial begin
    shadow_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_directed_edits();
    test_pool_exhaustion();
    test_random_traffic();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
